// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, clocked on clk, gated by rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check on the block clock
`define NIOQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant check
`define NIOQ_ALWAYS(lbl, expr, msg) \
  `NIOQ_ASSERT(lbl, 1'b1 |-> (expr), msg)

`endif

// ----- src/nioq_pkg.sv -----
// ---------------------------------------------------------------------------
// nioq_pkg
// types and codes shared by the containment list query block
// ---------------------------------------------------------------------------
package nioq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_ENTRY  = 2'd0,
    OP_LOAD_HEADER = 2'd1,
    OP_QUERY       = 2'd2,
    OP_CONTINUE    = 2'd3
  } op_e;

  typedef enum logic {
    CFG_TOP_COUNT    = 1'b0,
    CFG_BUFFER_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BS_RD,
    S_BS_CMP,
    S_BS_FIN,
    S_BS_END,
    S_RUN_RD,
    S_RUN_CHK,
    S_HD_CHK,
    S_POP_LD,
    S_DR_HB,
    S_DR_ENT,
    S_DR_OUT,
    S_DR_WAIT
  } state_t;

  typedef struct packed {
    logic signed [31:0] start_v;
    logic signed [31:0] end_v;
    logic signed [31:0] ident;
    logic signed [31:0] tbegin;
    logic signed [31:0] tfinish;
    logic signed [14:0] child;
  } entry_t;

  typedef struct packed {
    logic [15:0] offset;
    logic [16:0] length;
  } hdr_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ----- src/nioq_store.sv -----
// ---------------------------------------------------------------------------
// nioq_store
// entry and sublist header memories, one write and one registered read each
// ---------------------------------------------------------------------------
module nioq_store #(
  parameter int ENTRY_DEPTH = 65536,
  parameter int LIST_DEPTH  = 16384
) (
  input  logic                                   clk,
  input  logic                                   ent_we,
  input  logic [$clog2(ENTRY_DEPTH)-1:0]         ent_waddr,
  input  nioq_pkg::entry_t                       ent_wdata,
  input  logic [$clog2(ENTRY_DEPTH)-1:0]         ent_raddr,
  output nioq_pkg::entry_t                       ent_rdata,
  input  logic                                   hdr_we,
  input  logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] hdr_waddr,
  input  nioq_pkg::hdr_t                         hdr_wdata,
  input  logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] hdr_raddr,
  output nioq_pkg::hdr_t                         hdr_rdata
);
  import nioq_pkg::*;

  entry_t ent_mem [ENTRY_DEPTH];
  hdr_t   hdr_mem [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    hdr_rdata <= hdr_mem[hdr_raddr];
  end

endmodule

// ----- src/nioq_ctrl.sv -----
// ---------------------------------------------------------------------------
// nioq_ctrl
// search sequencer: binary search, overlap scan, iterator stack, hit drain
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nioq_ctrl #(
  parameter int ENTRY_DEPTH = 65536,
  parameter int LIST_DEPTH  = 16384,
  parameter int STACK_DEPTH = 64,
  parameter int MAX_BURST   = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  nioq_pkg::op_e                          in_op,
  input  logic [15:0]                            in_slot,
  input  logic signed [31:0]                     in_lo,
  input  logic signed [31:0]                     in_hi,
  input  logic [16:0]                            top_count,
  input  logic [6:0]                             buffer_limit,
  output logic                                   ent_we,
  output logic [$clog2(ENTRY_DEPTH)-1:0]         ent_waddr,
  output logic [$clog2(ENTRY_DEPTH)-1:0]         ent_raddr,
  input  nioq_pkg::entry_t                       ent_rdata,
  output logic                                   hdr_we,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] hdr_waddr,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] hdr_raddr,
  input  nioq_pkg::hdr_t                         hdr_rdata,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_found,
  output nioq_pkg::entry_t                       out_hit,
  output logic                                   out_last,
  output logic                                   out_more,
  output logic                                   out_overflow
);
  import nioq_pkg::*;

  localparam int EAW = $clog2(ENTRY_DEPTH);
  localparam int PW  = $clog2(ENTRY_DEPTH + 1);
  localparam int LAW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LVW = $clog2(STACK_DEPTH + 1);
  localparam int HBW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
  localparam int CW  = $clog2(MAX_BURST + 1);
  localparam logic [32:0] ED33 = 33'(ENTRY_DEPTH);
  localparam logic [32:0] LD33 = 33'(LIST_DEPTH);

  state_t state_r, state_nxt;

  logic signed [31:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic               ovf_r, ovf_nxt, live_r, live_nxt, paused_r, paused_nxt;
  logic               bs_top_r, bs_top_nxt, bs_ok_r, bs_ok_nxt;
  logic [LVW-1:0]     level_r, level_nxt;
  logic [PW-1:0]      tpos_r, tpos_nxt, tlim_r, tlim_nxt;
  logic [PW-1:0]      base_r, base_nxt, n_r, n_nxt, l_r, l_nxt, r_r, r_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [HBW-1:0]     dk_r, dk_nxt;
  logic               out_valid_r, out_valid_nxt, out_found_r, out_found_nxt;
  logic               out_last_r, out_last_nxt, out_more_r, out_more_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  entry_t             out_hit_r, out_hit_nxt;

  logic [2*PW-1:0]    stk_mem [STACK_DEPTH];
  logic [2*PW-1:0]    stk_q;
  logic               stk_we;
  logic [SAW-1:0]     stk_waddr, stk_raddr;
  logic [EAW-1:0]     hb_mem [MAX_BURST];
  logic [EAW-1:0]     hb_q;
  logic               hb_we;

  logic               accept, ovl, pos_in, child_ok, lt, can_push, hit_fit;
  logic [PW-1:0]      mid;
  logic [CW-1:0]      lim_eff;
  logic [32:0]        top_n33, hbase33, hlen33, hrem33, hn33;
  logic [PW-1:0]      top_n, hdr_base, hdr_n;

  // shared compare unit
  always_comb begin
    accept   = in_valid && (state_r == S_IDLE);
    ovl      = (lo_r < ent_rdata.end_v) && (ent_rdata.start_v < hi_r);
    pos_in   = tpos_r < tlim_r;
    child_ok = !ent_rdata.child[14] && (33'(ent_rdata.child) < LD33);
    lt       = l_r < r_r;
    mid      = PW'(({1'b0, l_r} + {1'b0, r_r}) >> 1);
    can_push = level_r < LVW'(STACK_DEPTH);
    if (buffer_limit == 7'd0) begin
      lim_eff = CW'(1);
    end else if (buffer_limit > 7'(MAX_BURST)) begin
      lim_eff = CW'(MAX_BURST);
    end else begin
      lim_eff = CW'(buffer_limit);
    end
    hit_fit  = ({1'b0, cnt_r} + 1'b1) < {1'b0, lim_eff};
    top_n33  = (33'(top_count) > ED33) ? ED33 : 33'(top_count);
    top_n    = PW'(top_n33);
    hbase33  = 33'(hdr_rdata.offset);
    hlen33   = 33'(hdr_rdata.length);
    hrem33   = ED33 - hbase33;
    if (hbase33 >= ED33) begin
      hn33 = '0;
    end else if (hlen33 > hrem33) begin
      hn33 = hrem33;
    end else begin
      hn33 = hlen33;
    end
    hdr_base = PW'(hbase33);
    hdr_n    = PW'(hn33);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_QUERY) begin
          state_nxt = S_BS_RD;
        end else if (accept && in_op == OP_CONTINUE) begin
          state_nxt = S_RUN_RD;
        end
      end
      S_BS_RD:   state_nxt = (n_r == '0) ? S_BS_END : (lt ? S_BS_CMP : S_BS_FIN);
      S_BS_CMP:  state_nxt = S_BS_RD;
      S_BS_FIN:  state_nxt = S_BS_END;
      S_BS_END: begin
        if (bs_top_r || hit_fit || cnt_r < lim_eff) begin
          state_nxt = S_RUN_RD;
        end else begin
          state_nxt = S_DR_HB;
        end
      end
      S_RUN_RD:  state_nxt = (live_r && level_r != '0) ? S_RUN_CHK : S_DR_HB;
      S_RUN_CHK: begin
        if (pos_in && ovl) begin
          if (child_ok) begin
            state_nxt = S_HD_CHK;
          end else begin
            state_nxt = hit_fit ? S_RUN_RD : S_DR_HB;
          end
        end else begin
          state_nxt = (level_r > LVW'(1)) ? S_POP_LD : S_RUN_RD;
        end
      end
      S_HD_CHK:  state_nxt = S_BS_RD;
      S_POP_LD:  state_nxt = S_RUN_RD;
      S_DR_HB:   state_nxt = S_DR_ENT;
      S_DR_ENT:  state_nxt = S_DR_OUT;
      S_DR_OUT:  state_nxt = S_DR_WAIT;
      S_DR_WAIT: begin
        if (out_ready) begin
          state_nxt = out_last_r ? S_IDLE : S_DR_HB;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    lo_nxt = lo_r;  hi_nxt = hi_r;  ovf_nxt = ovf_r;  live_nxt = live_r;
    paused_nxt = paused_r;  bs_top_nxt = bs_top_r;  bs_ok_nxt = bs_ok_r;
    level_nxt = level_r;  tpos_nxt = tpos_r;  tlim_nxt = tlim_r;
    base_nxt = base_r;  n_nxt = n_r;  l_nxt = l_r;  r_nxt = r_r;
    cnt_nxt = cnt_r;  dk_nxt = dk_r;
    out_valid_nxt = out_valid_r;  out_found_nxt = out_found_r;
    out_last_nxt = out_last_r;  out_more_nxt = out_more_r;
    out_ovf_nxt = out_ovf_r;  out_hit_nxt = out_hit_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        paused_nxt = 1'b0;
        dk_nxt = '0;
        if (accept && in_op == OP_QUERY) begin
          lo_nxt = in_lo;
          hi_nxt = in_hi;
          ovf_nxt = 1'b0;
          live_nxt = 1'b1;
          base_nxt = '0;
          n_nxt = top_n;
          l_nxt = '0;
          r_nxt = top_n - 1'b1;
          bs_top_nxt = 1'b1;
        end
      end
      S_BS_RD: begin
        if (n_r == '0) begin
          bs_ok_nxt = 1'b0;
        end
      end
      S_BS_CMP: begin
        if (ent_rdata.end_v <= lo_r) begin
          l_nxt = mid + 1'b1;
        end else begin
          r_nxt = mid;
        end
      end
      S_BS_FIN: bs_ok_nxt = ovl;
      S_BS_END: begin
        if (bs_top_r) begin
          tpos_nxt = bs_ok_r ? l_r : n_r;
          tlim_nxt = n_r;
          level_nxt = LVW'(1);
        end else if (bs_ok_r) begin
          if (can_push) begin
            tpos_nxt = base_r + l_r;
            tlim_nxt = base_r + n_r;
            level_nxt = level_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (!bs_top_r && cnt_r >= lim_eff) begin
          paused_nxt = 1'b1;
        end
      end
      S_RUN_RD: begin
        if (!(live_r && level_r != '0)) begin
          live_nxt = 1'b0;
          level_nxt = '0;
        end
      end
      S_RUN_CHK: begin
        if (pos_in && ovl) begin
          cnt_nxt = cnt_r + 1'b1;
          tpos_nxt = tpos_r + 1'b1;
          if (!child_ok && !hit_fit) begin
            paused_nxt = 1'b1;
          end
        end else begin
          level_nxt = level_r - 1'b1;
        end
      end
      S_HD_CHK: begin
        base_nxt = hdr_base;
        n_nxt = hdr_n;
        l_nxt = '0;
        r_nxt = hdr_n - 1'b1;
        bs_top_nxt = 1'b0;
      end
      S_POP_LD: begin
        tpos_nxt = stk_q[2*PW-1:PW];
        tlim_nxt = stk_q[PW-1:0];
      end
      S_DR_OUT: begin
        out_valid_nxt = 1'b1;
        out_ovf_nxt = ovf_r;
        if (cnt_r == '0) begin
          out_found_nxt = 1'b0;
          out_hit_nxt = '0;
          out_last_nxt = 1'b1;
          out_more_nxt = paused_r;
        end else begin
          out_found_nxt = 1'b1;
          out_hit_nxt = ent_rdata;
          out_last_nxt = (CW'(dk_r) == cnt_r - 1'b1);
          out_more_nxt = (CW'(dk_r) == cnt_r - 1'b1) && paused_r;
        end
      end
      S_DR_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          dk_nxt = dk_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    ent_we    = accept && in_op == OP_LOAD_ENTRY && (33'(in_slot) < ED33);
    ent_waddr = EAW'(in_slot);
    hdr_we    = accept && in_op == OP_LOAD_HEADER && (33'(in_slot) < LD33);
    hdr_waddr = LAW'(in_slot);
    hdr_raddr = LAW'(ent_rdata.child[13:0]);
    unique case (state_r)
      S_BS_RD:  ent_raddr = EAW'(base_r + (lt ? mid : l_r));
      S_DR_ENT: ent_raddr = hb_q;
      default:  ent_raddr = EAW'(tpos_r);
    endcase
    stk_we    = (state_r == S_BS_END) && !bs_top_r && bs_ok_r && can_push;
    stk_waddr = SAW'(level_r - 1'b1);
    stk_raddr = SAW'(level_r - LVW'(2));
    hb_we     = (state_r == S_RUN_CHK) && pos_in && ovl;
    out_valid    = out_valid_r;
    out_found    = out_found_r;
    out_hit      = out_hit_r;
    out_last     = out_last_r;
    out_more     = out_more_r;
    out_overflow = out_ovf_r;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= {tpos_r, tlim_r};
    end
    stk_q <= stk_mem[stk_raddr];
    if (hb_we) begin
      hb_mem[cnt_r[HBW-1:0]] <= EAW'(tpos_r);
    end
    hb_q <= hb_mem[dk_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lo_r        <= '0;
      hi_r        <= '0;
      ovf_r       <= 1'b0;
      live_r      <= 1'b0;
      paused_r    <= 1'b0;
      level_r     <= '0;
      cnt_r       <= '0;
      dk_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      ovf_r       <= ovf_nxt;
      live_r      <= live_nxt;
      paused_r    <= paused_nxt;
      level_r     <= level_nxt;
      cnt_r       <= cnt_nxt;
      dk_r        <= dk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bs_top_r    <= bs_top_nxt;
    bs_ok_r     <= bs_ok_nxt;
    tpos_r      <= tpos_nxt;
    tlim_r      <= tlim_nxt;
    base_r      <= base_nxt;
    n_r         <= n_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
    out_more_r  <= out_more_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  `NIOQ_ASSERT(a_idle_no_result, (state_r == S_IDLE) |-> !out_valid_r, "result pending in idle")
  `NIOQ_ALWAYS(a_level_bound, level_r <= LVW'(STACK_DEPTH), "iterator stack overrun")
  `NIOQ_ASSERT(a_scan_room, (state_r == S_RUN_CHK) |-> (cnt_r < lim_eff), "hit list overrun")

endmodule

// ----- src/nested_interval_overlap_query.sv -----
// ---------------------------------------------------------------------------
// nested_interval_overlap_query
// overlap search over a host-built nested containment list
// ---------------------------------------------------------------------------
// Load items (entry or sublist header) are written when accepted. A query or
// continue runs on one shared compare unit over the entry memory, whose read is
// registered: the item is taken, then per searched list come binary search steps
// (log2 of the list length), each a read and a compare, and a final overlap check
// and stack update; each entry checked is read, then checked; a sublist header
// lookup or a return to a parent list adds a state; results drain one by one when
// the output is ready. The block takes no new item until the last result of the
// call has been transferred. No clearing pass follows reset.
module nested_interval_overlap_query #(
  parameter int ENTRY_DEPTH = 65536,
  parameter int LIST_DEPTH  = 16384,
  parameter int STACK_DEPTH = 64,
  parameter int MAX_BURST   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot, lo_bound, hi_bound, target_ident, target_begin, target_finish,
  // child_list, list_offset, list_length
  input  logic [223:0] s_tdata,
  // operation
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_start, hit_end, hit_target_ident, hit_target_begin, hit_target_finish,
  // hit_child_list, more, overflow, zero pad
  output logic [183:0] m_tdata,
  // found
  output logic [0:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  import nioq_pkg::*;

  localparam int EAW = $clog2(ENTRY_DEPTH);
  localparam int LAW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [16:0]    top_count_r, top_count_nxt;
  logic [6:0]     buffer_limit_r, buffer_limit_nxt;
  entry_t         ent_wdata, ent_rdata, out_hit;
  hdr_t           hdr_wdata, hdr_rdata;
  logic           ent_we, hdr_we, out_found, out_more, out_overflow;
  logic [EAW-1:0] ent_waddr, ent_raddr;
  logic [LAW-1:0] hdr_waddr, hdr_raddr;

  assign cfg_ready = 1'b1;

  always_comb begin
    top_count_nxt    = top_count_r;
    buffer_limit_nxt = buffer_limit_r;
    if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_TOP_COUNT:    top_count_nxt = cfg_data;
        CFG_BUFFER_LIMIT: buffer_limit_nxt = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r    <= '0;
      buffer_limit_r <= 7'd64;
    end else begin
      top_count_r    <= top_count_nxt;
      buffer_limit_r <= buffer_limit_nxt;
    end
  end

  always_comb begin
    ent_wdata.start_v = s_tdata[47:16];
    ent_wdata.end_v   = s_tdata[79:48];
    ent_wdata.ident   = s_tdata[111:80];
    ent_wdata.tbegin  = s_tdata[143:112];
    ent_wdata.tfinish = s_tdata[175:144];
    ent_wdata.child   = s_tdata[190:176];
    hdr_wdata.offset  = s_tdata[206:191];
    hdr_wdata.length  = s_tdata[223:207];
    m_tdata = {7'd0, out_overflow, out_more, out_hit.child, out_hit.tfinish,
               out_hit.tbegin, out_hit.ident, out_hit.end_v, out_hit.start_v};
    m_tuser = out_found;
  end

  nioq_store #(
    .ENTRY_DEPTH(ENTRY_DEPTH),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_store (
    .clk      (clk),
    .ent_we   (ent_we),
    .ent_waddr(ent_waddr),
    .ent_wdata(ent_wdata),
    .ent_raddr(ent_raddr),
    .ent_rdata(ent_rdata),
    .hdr_we   (hdr_we),
    .hdr_waddr(hdr_waddr),
    .hdr_wdata(hdr_wdata),
    .hdr_raddr(hdr_raddr),
    .hdr_rdata(hdr_rdata)
  );

  nioq_ctrl #(
    .ENTRY_DEPTH(ENTRY_DEPTH),
    .LIST_DEPTH (LIST_DEPTH),
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_BURST  (MAX_BURST)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (op_e'(s_tuser)),
    .in_slot     (s_tdata[15:0]),
    .in_lo       (s_tdata[47:16]),
    .in_hi       (s_tdata[79:48]),
    .top_count   (top_count_r),
    .buffer_limit(buffer_limit_r),
    .ent_we      (ent_we),
    .ent_waddr   (ent_waddr),
    .ent_raddr   (ent_raddr),
    .ent_rdata   (ent_rdata),
    .hdr_we      (hdr_we),
    .hdr_waddr   (hdr_waddr),
    .hdr_raddr   (hdr_raddr),
    .hdr_rdata   (hdr_rdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_found   (out_found),
    .out_hit     (out_hit),
    .out_last    (m_tlast),
    .out_more    (out_more),
    .out_overflow(out_overflow)
  );

endmodule

// ----- tb/tb_nested_interval_overlap_query.sv -----
// ---------------------------------------------------------------------------
// tb_nested_interval_overlap_query
// self-checking bench for the nested containment list overlap search: loads
// built lists, runs queries and continues with random stalls on both sides,
// and checks every result against a transaction-level predictor
// ---------------------------------------------------------------------------
module tb_nested_interval_overlap_query;
  import nioq_pkg::*;

  // input transfer layout, first field in the lowest bits
  typedef struct packed {
    logic [16:0]        length;
    logic [15:0]        offset;
    logic signed [14:0] child;
    logic signed [31:0] tfinish;
    logic signed [31:0] tbegin;
    logic signed [31:0] ident;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic [15:0]        slot;
  } item_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic               ovf;
    logic               more;
    logic signed [14:0] child;
    logic signed [31:0] tfinish;
    logic signed [31:0] tbegin;
    logic signed [31:0] ident;
    logic signed [31:0] end_v;
    logic signed [31:0] start_v;
  } hit_t;

  typedef struct packed {
    logic found;
    hit_t data;
    logic last;
  } hit_rec_t;

  class hit_scoreboard;
    entry_t ent_mem[int];
    hdr_t hdr_mem[int];
    int unsigned pos_stk[64];
    int unsigned lim_stk[64];
    int unsigned lvl, top_cnt, burst;
    logic signed [31:0] qlo, qhi;
    bit live, ovf_seen;
    hit_rec_t pending[$];
    int errors, n_items, n_calls, n_hits;

    function new();
      top_cnt = 0;
      burst = 64;
    endfunction

    function void set_reg(cfg_idx_e idx, int unsigned val);
      if (idx == CFG_TOP_COUNT) top_cnt = val & 17'h1ffff;
      else burst = val & 7'h7f;
    endfunction

    function bit overlaps(int unsigned i);
      return qlo < ent_mem[i].end_v && ent_mem[i].start_v < qhi;
    endfunction

    function int unsigned clip(int unsigned b, int unsigned n);
      if (b >= 65536) return 0;
      if (n > 65536 - b) return 65536 - b;
      return n;
    endfunction

    function int unsigned first_hit(int unsigned b, int unsigned n);
      int unsigned l, r, mid;
      if (n == 0) return 0;
      l = 0;
      r = n - 1;
      while (l < r) begin
        mid = (l + r) / 2;
        if (ent_mem[b + mid].end_v <= qlo) l = mid + 1;
        else r = mid;
      end
      if (overlaps(b + l)) return l;
      return n;
    endfunction

    function void run_call();
      hit_rec_t got[$];
      hit_rec_t r;
      entry_t e;
      hdr_t h;
      int unsigned lim, t, p, n, j;
      bit paused;
      lim = burst;
      if (lim == 0) lim = 1;
      if (lim > 64) lim = 64;
      paused = 0;
      while (live && lvl > 0 && !paused) begin
        t = lvl - 1;
        p = pos_stk[t];
        if (p < lim_stk[t] && overlaps(p)) begin
          e = ent_mem[p];
          r = '0;
          r.found = 1;
          r.data.start_v = e.start_v;
          r.data.end_v = e.end_v;
          r.data.ident = e.ident;
          r.data.tbegin = e.tbegin;
          r.data.tfinish = e.tfinish;
          r.data.child = e.child;
          got.push_back(r);
          pos_stk[t] = p + 1;
          if (e.child >= 0) begin
            h = hdr_mem[int'(e.child)];
            n = clip(h.offset, h.length);
            j = first_hit(h.offset, n);
            if (j < n) begin
              if (lvl < 64) begin
                pos_stk[lvl] = h.offset + j;
                lim_stk[lvl] = h.offset + n;
                lvl++;
              end else begin
                ovf_seen = 1;
              end
            end
          end
          if (got.size() >= lim) paused = 1;
        end else begin
          lvl--;
        end
      end
      if (!paused) begin
        live = 0;
        lvl = 0;
      end
      n_hits += got.size();
      if (got.size() == 0) got.push_back('0);
      foreach (got[k]) got[k].data.ovf = ovf_seen;
      got[got.size() - 1].last = 1;
      got[got.size() - 1].data.more = paused;
      foreach (got[k]) pending.push_back(got[k]);
      n_calls++;
    endfunction

    function void note_input(op_e op, item_t d);
      entry_t e;
      hdr_t h;
      int unsigned n;
      n_items++;
      case (op)
        OP_LOAD_ENTRY: begin
          e.start_v = d.lo;
          e.end_v = d.hi;
          e.ident = d.ident;
          e.tbegin = d.tbegin;
          e.tfinish = d.tfinish;
          e.child = d.child;
          ent_mem[int'(d.slot)] = e;
        end
        OP_LOAD_HEADER: begin
          h.offset = d.offset;
          h.length = d.length;
          if (d.slot < 16384) hdr_mem[int'(d.slot)] = h;
        end
        OP_QUERY: begin
          n = clip(0, top_cnt);
          qlo = d.lo;
          qhi = d.hi;
          ovf_seen = 0;
          pos_stk[0] = first_hit(0, n);
          lim_stk[0] = n;
          lvl = 1;
          live = 1;
          run_call();
        end
        default: run_call();
      endcase
    endfunction

    function void check_result(logic found, hit_t d, logic last);
      hit_rec_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result found=%0b data=%h", $time, found, d);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x.found !== found) begin
        $display("%0t: found exp %0b got %0b", $time, x.found, found);
        errors++;
      end
      if (x.data.start_v !== d.start_v) begin
        $display("%0t: hit_start exp %0d got %0d", $time, x.data.start_v, d.start_v);
        errors++;
      end
      if (x.data.end_v !== d.end_v) begin
        $display("%0t: hit_end exp %0d got %0d", $time, x.data.end_v, d.end_v);
        errors++;
      end
      if (x.data.ident !== d.ident) begin
        $display("%0t: hit_target_ident exp %0d got %0d", $time, x.data.ident, d.ident);
        errors++;
      end
      if (x.data.tbegin !== d.tbegin) begin
        $display("%0t: hit_target_begin exp %0d got %0d", $time, x.data.tbegin, d.tbegin);
        errors++;
      end
      if (x.data.tfinish !== d.tfinish) begin
        $display("%0t: hit_target_finish exp %0d got %0d", $time, x.data.tfinish,
                 d.tfinish);
        errors++;
      end
      if (x.data.child !== d.child) begin
        $display("%0t: hit_child_list exp %0d got %0d", $time, x.data.child, d.child);
        errors++;
      end
      if (x.data.more !== d.more) begin
        $display("%0t: more exp %0b got %0b", $time, x.data.more, d.more);
        errors++;
      end
      if (x.data.ovf !== d.ovf) begin
        $display("%0t: overflow exp %0b got %0b", $time, x.data.ovf, d.ovf);
        errors++;
      end
      if (x.data.pad !== d.pad) begin
        $display("%0t: pad exp %h got %h", $time, x.data.pad, d.pad);
        errors++;
      end
      if (x.last !== last) begin
        $display("%0t: last exp %0b got %0b", $time, x.last, last);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [183:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [0:0]   cfg_index;
  logic [16:0]  cfg_data;

  hit_scoreboard sb;
  bit no_idle;
  int stall_left;
  int quiet_cycles;
  int unsigned ent_next;

  nested_interval_overlap_query u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: check, stall and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      m_tready <= 0;
      stall_left <= 0;
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tuser[0], hit_t'(m_tdata), m_tlast);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("%0t: watchdog expired", $time);
        $display("FAILED: results differ");
        $finish;
      end
      if (stall_left > 0) begin
        m_tready <= 0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1;
        if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
      end
    end
  end

  task automatic send_item(op_e op, item_t d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, d);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    wait_idle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_entry(int slot, int st, int en, int id, int tb, int tf, int ch);
    item_t d;
    d = '0;
    d.slot = slot[15:0];
    d.lo = st;
    d.hi = en;
    d.ident = id;
    d.tbegin = tb;
    d.tfinish = tf;
    d.child = ch[14:0];
    send_item(OP_LOAD_ENTRY, d);
  endtask

  task automatic load_header(int slot, int unsigned off, int unsigned len);
    item_t d;
    d = '0;
    d.slot = slot[15:0];
    d.offset = off[15:0];
    d.length = len[16:0];
    send_item(OP_LOAD_HEADER, d);
  endtask

  task automatic query(int lo, int hi);
    item_t d;
    int unsigned s;
    d = '0;
    d.lo = lo;
    d.hi = hi;
    s = $urandom;
    d.slot = s[15:0];
    send_item(OP_QUERY, d);
  endtask

  task automatic resume();
    send_item(OP_CONTINUE, item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom}));
  endtask

  // lists sorted by start with rising ends, sublists nested inside their parent
  task automatic make_list(int unsigned b, int unsigned n, int s0, int span, int lvl);
    int step, st, en, ch, h;
    int unsigned sub_b, m;
    step = span / int'(n + 2);
    if (step < 1) step = 1;
    for (int i = 0; i < n; i++) begin
      st = s0 + i * step + $urandom_range(0, step / 2);
      en = st + 2 * step + $urandom_range(0, step / 2);
      ch = -1;
      if (lvl < 3 && $urandom_range(0, 99) < 35) begin
        h = $urandom_range(0, 16383);
        m = $urandom_range(0, 4);
        sub_b = ent_next;
        ent_next += m;
        make_list(sub_b, m, st, en - st, lvl + 1);
        load_header(h, sub_b, m);
        ch = h;
      end
      load_entry(b + i, st, en, $urandom, $urandom, $urandom, ch);
    end
  endtask

  initial begin
    int unsigned top_n;
    int base, lo, r;
    sb = new();
    rst_n = 0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = OP_LOAD_ENTRY;
    cfg_valid = 0;
    cfg_index = CFG_TOP_COUNT;
    cfg_data = '0;
    no_idle = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: empty top list, paused-free continue, self-nesting sublist
    write_reg(CFG_TOP_COUNT, 0);
    query(0, 0);
    resume();
    load_entry(0, -5, 5, 32'h7fffffff, 32'h80000000, 0, 16000);
    load_header(16000, 0, 1);
    load_entry(1, 100, 200, -1, 0, 32'h7fffffff, 16383);
    load_header(16383, 65530, 65536);
    for (int k = 0; k < 6; k++)
      load_entry(65530 + k, 140 + k, 170 + k, $urandom, $urandom, $urandom, -1);
    load_header(65535, 0, 0);
    write_reg(CFG_TOP_COUNT, 2);
    query(-1, 1);
    resume();
    write_reg(CFG_BUFFER_LIMIT, 0);
    query(-1, 1);
    resume();
    resume();
    write_reg(CFG_BUFFER_LIMIT, 127);
    resume();
    query(150, 160);
    query(32'h80000000, 32'h7fffffff);
    resume();
    resume();
    query(10, -10);
    query(200, 300);
    resume();

    ent_next = 100;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      no_idle = (ph == 1);
      r = $urandom_range(0, 5);
      write_reg(CFG_BUFFER_LIMIT, r == 0 ? 64 : r == 1 ? $urandom_range(1, 127) : r);
      top_n = $urandom_range(4, 12);
      base = $urandom;
      make_list(0, top_n, base, 100000, 0);
      write_reg(CFG_TOP_COUNT, top_n);
      for (int i = 0; i < 35; i++) begin
        r = $urandom_range(0, 99);
        lo = base + $urandom_range(0, 105000) - 5000;
        if (r < 60) query(lo, lo + $urandom_range(0, 30000));
        else if (r < 90) resume();
        else query($urandom, $urandom);
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d query/continue calls, %0d hits",
             sb.n_items, sb.n_calls, sb.n_hits);
    $display("directed overflow and burst limits, then %0d random list sets", 4);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/nioq_pkg.sv
src/nioq_store.sv
src/nioq_ctrl.sv
src/nested_interval_overlap_query.sv
tb/tb_nested_interval_overlap_query.sv
